>>> sv/lasp_pkg.sv
// Shared types, constants and CORDIC helpers for the line/arc segment evaluator.
// Used by the top level, the CORDIC pipeline and the port checker. No dependencies.
package lasp_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CNT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int DIV_STEPS = 64;
  localparam int BEND_STEPS = 33;
  localparam int ITEM_LATENCY = DIV_STEPS + 5 + CORDIC_STAGES;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam logic signed [31:0] QMAX = 32'sd1073741824;
  localparam logic signed [31:0] QMIN = -32'sd1073741824;
  localparam logic [31:0] RAD_TO_BANG_Q2 = 32'd2734261102;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [31:0] RADIUS_RESET = 32'd65536;

  typedef enum logic [2:0] {
    REG_IS_ARC      = 3'd0,
    REG_START_X     = 3'd1,
    REG_START_Y     = 3'd2,
    REG_START_DIR   = 3'd3,
    REG_ARC_RADIUS  = 3'd4,
    REG_SWEPT       = 3'd5,
    REG_LINE_LENGTH = 3'd6
  } reg_idx_t;

  localparam logic [2:0] REG_LAST = REG_LINE_LENGTH;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cvec_t;

  typedef struct packed {
    logic [31:0] travel;
    logic [31:0] ang;
  } tag_t;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  // Angles past a quarter turn either way get a half-turn fold
  function automatic logic cordic_flip(input logic [31:0] ang);
    return ($signed(ang) > QMAX) || ($signed(ang) < QMIN);
  endfunction

  function automatic cvec_t cordic_init(input logic [31:0] ang);
    cvec_t v;
    logic [31:0] a;
    a = cordic_flip(ang) ? ang + HALF : ang;
    v.x = GAIN_Q30;
    v.y = '0;
    v.z = {{2{a[31]}}, a};
    return v;
  endfunction

  function automatic cvec_t cordic_step(input cvec_t v, input logic [4:0] i);
    cvec_t r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    dx = v.y >>> i;
    dy = v.x >>> i;
    at = $signed({4'b0, ATAN_TAB[i]});
    if (!v.z[33]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - at;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + at;
    end
    return r;
  endfunction

  // Round a Q30-scaled product to nearest (ties up), keep the low 32 bits
  function automatic logic [31:0] scale_round(input logic signed [66:0] prod);
    logic signed [66:0] s;
    s = prod + 67'sd536870912;
    return s[61:30];
  endfunction

  function automatic logic [31:0] eff_radius(input logic [31:0] r);
    return (r == 32'd0) ? 32'd1 : r;
  endfunction

endpackage

>>> sv/lasp_cordic_pipe.sv
// Fully pipelined rotation-mode CORDIC: one angle per cycle, cosine/sine in Q1.30.
// Carries a tag alongside each angle. Depends on lasp_pkg.
module lasp_cordic_pipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lasp_pkg::tag_t in_tag,
  output logic          out_valid,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin,
  output lasp_pkg::tag_t out_tag
);
  import lasp_pkg::*;

  cvec_t cv [CORDIC_STAGES+1];
  logic  fl [CORDIC_STAGES+1];
  tag_t  tg [CORDIC_STAGES+1];
  logic  vl [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else begin
      vl[0] <= in_valid;
    end
    cv[0] <= cordic_init(in_tag.ang);
    fl[0] <= cordic_flip(in_tag.ang);
    tg[0] <= in_tag;
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else begin
        vl[k+1] <= vl[k];
      end
      cv[k+1] <= cordic_step(cv[k], 5'(k));
      fl[k+1] <= fl[k];
      tg[k+1] <= tg[k];
    end
  end

  // Undo the half-turn fold on the way out
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vl[CORDIC_STAGES];
    end
    out_cos <= fl[CORDIC_STAGES] ? -cv[CORDIC_STAGES].x : cv[CORDIC_STAGES].x;
    out_sin <= fl[CORDIC_STAGES] ? -cv[CORDIC_STAGES].y : cv[CORDIC_STAGES].y;
    out_tag <= tg[CORDIC_STAGES];
  end

endmodule

>>> sv/line_arc_segment_point_eval_unit.sv
// Top level of the line/arc segment point evaluator.
// Depends on lasp_pkg and lasp_cordic_pipe.
//
// Usage:
//   Configuration: cfg_write, cfg_index, cfg_data write one register per cycle
//   (index 0 is_arc .. 6 line_length); other indexes are ignored. Each valid
//   write restarts a small background engine that rebuilds the arc center,
//   radial start angle, curvature and arc length, finishing well inside the
//   item latency.
//   Items: distance is taken at each edge where start is high; busy stays
//   low, so one item enters every cycle.
//   Results: pos_x, pos_y, tangent_dir, bend and seg_length appear with a
//   one-cycle done strobe, once the item has passed the 64-step pipelined
//   divider for arc progress followed by the CORDIC pipeline.
//   Throughput is one result per cycle, in acceptance order.
//   The receiver cannot stall; results are never held.
//   Reset: synchronous rst clears registers to their reset values, zeros the
//   arc center and empties the pipeline; items in flight are dropped.
module line_arc_segment_point_eval_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] distance,
  output logic        done,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] tangent_dir,
  output logic signed [31:0] bend,
  output logic [31:0] seg_length,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [33:0] cfg_data
);
  import lasp_pkg::*;

  // Configuration registers
  logic        is_arc;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] start_dir;
  logic [31:0] arc_radius;
  logic [33:0] swept;
  logic [31:0] line_length;

  logic        right;
  logic [31:0] reff;
  assign right = swept[33];
  assign reff  = eff_radius(arc_radius);
  assign busy  = 1'b0;

  logic eng_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_arc      <= 1'b0;
      start_x     <= '0;
      start_y     <= '0;
      start_dir   <= '0;
      arc_radius  <= RADIUS_RESET;
      swept       <= '0;
      line_length <= '0;
      eng_load    <= 1'b0;
    end else begin
      eng_load <= cfg_write && (cfg_index <= REG_LAST);
      if (cfg_write) begin
        case (cfg_index)
          REG_IS_ARC:      is_arc      <= cfg_data[0];
          REG_START_X:     start_x     <= cfg_data[31:0];
          REG_START_Y:     start_y     <= cfg_data[31:0];
          REG_START_DIR:   start_dir   <= cfg_data[31:0];
          REG_ARC_RADIUS:  arc_radius  <= cfg_data[31:0];
          REG_SWEPT:       swept       <= cfg_data;
          REG_LINE_LENGTH: line_length <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- background engine: arc center ----------------
  logic [31:0] cdir;
  assign cdir = right ? start_dir - QUARTER : start_dir + QUARTER;

  cvec_t             ec_v;
  logic              ec_flip;
  logic [CNT_W-1:0]  ec_cnt;
  logic              ec_run;
  logic              ec_fin;
  logic              ec_mul;
  logic signed [66:0] ec_px;
  logic signed [66:0] ec_py;
  logic [31:0]       center_x;
  logic [31:0]       center_y;
  logic [31:0]       radial_start_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      ec_run             <= 1'b0;
      ec_fin             <= 1'b0;
      ec_mul             <= 1'b0;
      center_x           <= '0;
      center_y           <= '0;
      radial_start_angle <= '0;
    end else begin
      ec_fin <= 1'b0;
      ec_mul <= ec_fin;
      if (eng_load) begin
        ec_v               <= cordic_init(cdir);
        ec_flip            <= cordic_flip(cdir);
        ec_cnt             <= '0;
        ec_run             <= 1'b1;
        radial_start_angle <= cdir + HALF;
      end else if (ec_run) begin
        ec_v <= cordic_step(ec_v, 5'(ec_cnt));
        if (ec_cnt == CNT_W'(CORDIC_STAGES - 1)) begin
          ec_run <= 1'b0;
          ec_fin <= 1'b1;
        end else begin
          ec_cnt <= ec_cnt + 1'b1;
        end
      end
      if (ec_fin) begin
        ec_px <= $signed({1'b0, reff}) * (ec_flip ? -ec_v.x : ec_v.x);
        ec_py <= $signed({1'b0, reff}) * (ec_flip ? -ec_v.y : ec_v.y);
      end
      if (ec_mul) begin
        center_x <= start_x + scale_round(ec_px);
        center_y <= start_y + scale_round(ec_py);
      end
    end
  end

  // ---------------- background engine: curvature ----------------
  logic [32:0] bd_num;
  logic [31:0] bd_rem;
  logic [32:0] bd_q;
  logic [5:0]  bd_cnt;
  logic        bd_run;
  logic        bd_fin;
  logic [31:0] bend_arc;
  logic [32:0] bd_try;
  logic        bd_ge;
  logic [32:0] bd_diff;

  always_comb begin
    bd_try  = {bd_rem, bd_num[32]};
    bd_ge   = bd_try >= {1'b0, reff};
    bd_diff = bd_try - {1'b0, reff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bd_run <= 1'b0;
      bd_fin <= 1'b0;
    end else begin
      bd_fin <= 1'b0;
      if (eng_load) begin
        bd_num <= 33'h1_0000_0000 + {2'b0, reff[31:1]};
        bd_rem <= '0;
        bd_q   <= '0;
        bd_cnt <= '0;
        bd_run <= 1'b1;
      end else if (bd_run) begin
        bd_rem <= bd_ge ? bd_diff[31:0] : bd_try[31:0];
        bd_num <= {bd_num[31:0], 1'b0};
        bd_q   <= {bd_q[31:0], bd_ge};
        if (bd_cnt == 6'(BEND_STEPS - 1)) begin
          bd_run <= 1'b0;
          bd_fin <= 1'b1;
        end else begin
          bd_cnt <= bd_cnt + 1'b1;
        end
      end
      if (bd_fin) begin
        if (!right) begin
          bend_arc <= (bd_q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : bd_q[31:0];
        end else begin
          bend_arc <= (bd_q > 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - bd_q[31:0];
        end
      end
    end
  end

  // ---------------- background engine: arc length ----------------
  logic [33:0] ln_m;
  logic        ln_full;
  logic [31:0] ln_mlo;
  logic [63:0] ln_p;
  logic [63:0] ln_lo;
  logic [63:0] ln_hi;
  logic [96:0] ln_sum;
  logic        ln_v1;
  logic        ln_v2;
  logic        ln_v3;
  logic [31:0] len_arc;

  always_comb begin
    ln_m   = right ? 34'd0 - swept : swept;
    ln_sum = ({33'b0, ln_hi} << 32) + {33'b0, ln_lo} + (97'd1 << 60);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ln_v1 <= 1'b0;
      ln_v2 <= 1'b0;
      ln_v3 <= 1'b0;
    end else begin
      ln_v1 <= eng_load;
      ln_v2 <= ln_v1;
      ln_v3 <= ln_v2;
    end
    if (eng_load) begin
      // a sweep above one turn counts as one turn
      ln_full <= ln_m >= 34'h1_0000_0000;
      ln_mlo  <= ln_m[31:0];
    end
    if (ln_v1) begin
      ln_p <= ln_full ? {reff, 32'b0} : reff * ln_mlo;
    end
    if (ln_v2) begin
      ln_lo <= ln_p[31:0] * TWO_PI_Q29;
      ln_hi <= ln_p[63:32] * TWO_PI_Q29;
    end
    if (ln_v3) begin
      len_arc <= (ln_sum[96:93] != 4'd0) ? 32'hFFFF_FFFF : ln_sum[92:61];
    end
  end

  // ---------------- item pipeline: arc progress divider ----------------
  logic        dv_v   [DIV_STEPS+1];
  logic [63:0] dv_dvd [DIV_STEPS+1];
  logic [31:0] dv_rem [DIV_STEPS+1];
  logic [33:0] dv_q   [DIV_STEPS+1];
  logic [31:0] dv_d   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= start && !busy;
    end
    dv_dvd[0] <= distance * RAD_TO_BANG_Q2;
    dv_rem[0] <= '0;
    dv_q[0]   <= '0;
    dv_d[0]   <= distance;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] try_w;
    logic        ge_w;
    logic [32:0] diff_w;
    always_comb begin
      try_w  = {dv_rem[k], dv_dvd[k][63]};
      ge_w   = try_w >= {1'b0, reff};
      diff_w = try_w - {1'b0, reff};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
      dv_rem[k+1] <= ge_w ? diff_w[31:0] : try_w[31:0];
      dv_dvd[k+1] <= {dv_dvd[k][62:0], 1'b0};
      dv_q[k+1]   <= {dv_q[k][32:0], ge_w};
      dv_d[k+1]   <= dv_d[k];
    end
  end

  // ---------------- angle, CORDIC, scale, offset ----------------
  logic [33:0] adv;
  logic [31:0] arc_ang;
  tag_t        cp_in;
  logic        cp_v;
  logic signed [33:0] cp_cos;
  logic signed [33:0] cp_sin;
  tag_t        cp_tag;

  always_comb begin
    adv          = dv_q[DIV_STEPS] + 34'd2;
    arc_ang      = right ? radial_start_angle - adv[33:2] : radial_start_angle + adv[33:2];
    cp_in.travel = dv_d[DIV_STEPS];
    cp_in.ang    = is_arc ? arc_ang : start_dir;
  end

  lasp_cordic_pipe u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_v[DIV_STEPS]),
    .in_tag    (cp_in),
    .out_valid (cp_v),
    .out_cos   (cp_cos),
    .out_sin   (cp_sin),
    .out_tag   (cp_tag)
  );

  logic              p_v;
  logic signed [66:0] p_x;
  logic signed [66:0] p_y;
  logic [31:0]       p_ang;
  logic [31:0]       mag;

  assign mag = is_arc ? reff : cp_tag.travel;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      p_v  <= cp_v;
      done <= p_v;
    end
    p_x   <= $signed({1'b0, mag}) * cp_cos;
    p_y   <= $signed({1'b0, mag}) * cp_sin;
    p_ang <= cp_tag.ang;
    pos_x <= (is_arc ? center_x : start_x) + scale_round(p_x);
    pos_y <= (is_arc ? center_y : start_y) + scale_round(p_y);
    if (is_arc) begin
      tangent_dir <= right ? p_ang - QUARTER : p_ang + QUARTER;
      bend        <= bend_arc;
      seg_length  <= len_arc;
    end else begin
      tangent_dir <= start_dir;
      bend        <= '0;
      seg_length  <= line_length;
    end
  end

endmodule

>>> sv/lasp_checker.sv
// Port-level checker for the segment evaluator, bound to the top level.
// Depends on lasp_pkg for the item latency.
module lasp_port_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import lasp_pkg::*;

  // every result beat traces back to an accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ITEM_LATENCY))
    else $error("result beat without a matching accepted item");

  // every accepted item yields its result beat after the fixed latency
  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##ITEM_LATENCY done)
    else $error("accepted item produced no result beat");

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

endmodule

bind line_arc_segment_point_eval_unit lasp_port_checker u_lasp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

>>> tb/lasp_checker.sv
// Result checker for the line/arc segment point evaluator.
// Mirrors configuration writes, predicts each result from accepted distance beats.
// Depends on lasp_pkg for register indexes and the stage count.
module lasp_checker
  import lasp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] distance,
  input  logic        done,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] tangent_dir,
  input  logic [31:0] bend,
  input  logic [31:0] seg_length,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [33:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          points_seen
);

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] dir;
    logic [31:0] bend;
    logic [31:0] len;
  } point_t;

  localparam longint ATAN_VAL [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };
  localparam logic [31:0] QTR = 32'h4000_0000;

  point_t      point_q[$];
  logic        arc_mode;
  logic [31:0] sx, sy, sdir, radius, llen, cx, cy, rad_ang;
  logic [33:0] sweep;

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
    longint z, x, y, dx, dy;
    logic [31:0] a;
    bit flip;
    z = longint'($signed(ang));
    flip = (z > 64'sd1073741824) || (z < -64'sd1073741824);
    a = flip ? ang + 32'h8000_0000 : ang;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_VAL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_VAL[i];
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  // 33x31-bit products overflow 64 bits: use 128-bit math
  function automatic logic [31:0] offset(logic [31:0] base, logic [63:0] mag, longint unit);
    logic signed [127:0] p;
    p = $signed({64'd0, mag}) * $signed(128'(unit)) + 128'sd536870912;
    p = p >>> 30;
    return base + p[31:0];
  endfunction

  function automatic logic [63:0] r_eff();
    return (radius == 0) ? 64'd1 : {32'd0, radius};
  endfunction

  task automatic rebuild();
    logic [31:0] cdir;
    longint co, si;
    cdir = sdir + (sweep[33] ? -QTR : QTR);
    rotate(cdir, co, si);
    cx = offset(sx, r_eff(), co);
    cy = offset(sy, r_eff(), si);
    rad_ang = cdir + 32'h8000_0000;
  endtask

  function automatic logic [31:0] arc_length();
    logic [63:0] m;
    logic [127:0] l;
    m = sweep[33] ? (64'd1 << 34) - sweep : {30'd0, sweep};
    if (m > (64'd1 << 32)) m = 64'd1 << 32;
    l = 128'(r_eff() * m) * 128'd3373259426 + (128'd1 << 60);
    l = l >> 61;
    return (l > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
  endfunction

  function automatic logic [31:0] curvature();
    logic [63:0] q;
    q = ((64'd1 << 32) + r_eff() / 2) / r_eff();
    if (!sweep[33]) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
  endfunction

  task automatic eval_point(input logic [31:0] d, output point_t p);
    longint co, si;
    logic [127:0] q;
    logic [31:0] adv, ang;
    if (!arc_mode) begin
      rotate(sdir, co, si);
      p.px = offset(sx, {32'd0, d}, co);
      p.py = offset(sy, {32'd0, d}, si);
      p.dir = sdir;
      p.bend = 0;
      p.len = llen;
    end else begin
      q = (128'(d) * 128'd2734261102) / 128'(r_eff());
      q = (q + 2) >> 2;
      adv = q[31:0];
      ang = rad_ang + (sweep[33] ? -adv : adv);
      rotate(ang, co, si);
      p.px = offset(cx, r_eff(), co);
      p.py = offset(cy, r_eff(), si);
      p.dir = ang + (sweep[33] ? -QTR : QTR);
      p.bend = curvature();
      p.len = arc_length();
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    if (fail_count < 10)
      $display("mismatch %s: expected %h got %h", what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      arc_mode = 0; sx = 0; sy = 0; sdir = 0; radius = 32'd65536; sweep = 0;
      llen = 0; cx = 0; cy = 0; rad_ang = 0;
      point_q.delete();
      fail_count = 0;
      points_seen = 0;
    end else begin
      if (done) begin
        points_seen++;
        if (point_q.size() == 0) begin
          flag("unexpected beat", 0, pos_x);
        end else begin
          p = point_q.pop_front();
          if (pos_x !== p.px) flag("pos_x", p.px, pos_x);
          if (pos_y !== p.py) flag("pos_y", p.py, pos_y);
          if (tangent_dir !== p.dir) flag("tangent_dir", p.dir, tangent_dir);
          if (bend !== p.bend) flag("bend", p.bend, bend);
          if (seg_length !== p.len) flag("seg_length", p.len, seg_length);
        end
      end
      // items accepted this edge see the configuration as before the edge
      if (start && !busy) begin
        eval_point(distance, p);
        point_q.push_back(p);
      end
      if (cfg_write && cfg_index <= REG_LAST) begin
        case (reg_idx_t'(cfg_index))
          REG_IS_ARC:      arc_mode = cfg_data[0];
          REG_START_X:     sx = cfg_data[31:0];
          REG_START_Y:     sy = cfg_data[31:0];
          REG_START_DIR:   sdir = cfg_data[31:0];
          REG_ARC_RADIUS:  radius = cfg_data[31:0];
          REG_SWEPT:       sweep = cfg_data;
          REG_LINE_LENGTH: llen = cfg_data[31:0];
          default: ;
        endcase
        rebuild();
      end
    end
    pending = point_q.size();
  end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the line/arc segment point evaluator.
// Depends on lasp_pkg, line_arc_segment_point_eval_unit and lasp_checker.
module tb_top;
  import lasp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [31:0] distance = 0;
  logic        cfg_write = 0;
  logic [2:0]  cfg_index = 0;
  logic [33:0] cfg_data = 0;
  logic        busy, done;
  logic signed [31:0] pos_x, pos_y, tangent_dir, bend;
  logic [31:0] seg_length;
  int          fail_count, pending, points_seen;
  int          idle_run;
  int          n_cfg;

  always #2 clk = ~clk;

  line_arc_segment_point_eval_unit dut (.*);
  lasp_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  // drop start and wait until every beat in flight has come out
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ITEM_LATENCY + 50) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [33:0] val);
    drain();
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    n_cfg++;
  endtask

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // one beat; optional idle burst before it
  task automatic send(input logic [31:0] d, input bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start <= 1;
    distance <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_setting(input int k);
    logic [33:0] sw;
    write_reg(REG_IS_ARC, 34'($urandom_range(0, 1)));
    write_reg(REG_START_X, 34'({$urandom(), $urandom()}));
    write_reg(REG_START_Y, 34'({$urandom(), $urandom()}));
    write_reg(REG_START_DIR, 34'({$urandom(), $urandom()}));
    case (k % 4)
      0: write_reg(REG_ARC_RADIUS, 34'($urandom()));
      1: write_reg(REG_ARC_RADIUS, 34'($urandom_range(0, 8)));
      2: write_reg(REG_ARC_RADIUS, 34'hFFFF_FFFF);
      default: write_reg(REG_ARC_RADIUS, 34'($urandom_range(65536, 65536 * 200)));
    endcase
    case (k % 3)
      0: sw = 34'({$urandom(), $urandom()});
      1: sw = 34'd1 << 32;
      default: sw = -(34'd1 << 32) - 34'($urandom_range(0, 3));
    endcase
    write_reg(REG_SWEPT, sw);
    write_reg(REG_LINE_LENGTH, 34'({$urandom(), $urandom()}));
  endtask

  initial begin
    n_cfg = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // straight items right after reset, then an arc from the reset configuration
    send(32'd0, 0);
    send(32'hFFFF_FFFF, 0);
    write_reg(REG_IS_ARC, 34'd1);
    send(32'd65536, 0);
    drain();
    // directed extremes
    write_reg(REG_ARC_RADIUS, 34'd0);
    send(32'hFFFF_FFFF, 0);
    send(32'd1, 0);
    write_reg(REG_ARC_RADIUS, 34'hFFFF_FFFF);
    write_reg(REG_SWEPT, 34'h3_FFFF_FFFF);
    send(32'd0, 0);
    send(32'hFFFF_FFFF, 0);
    write_reg(REG_SWEPT, 34'h1_FFFF_FFFF);
    write_reg(REG_START_X, 34'h7FFF_FFFF);
    write_reg(REG_START_Y, 34'h8000_0000);
    write_reg(REG_START_DIR, 34'h8000_0000);
    send(32'h8000_0000, 0);
    write_reg(REG_IS_ARC, 34'd0);
    write_reg(REG_LINE_LENGTH, 34'hFFFF_FFFF);
    send(32'hFFFF_FFFF, 0);
    send(32'd12345, 0);
    start <= 0;
    @(posedge clk);
    write_reg(reg_idx_t'(3'd7), 34'h3_FFFF_FFFF);
    send(32'd777, 0);
    start <= 0;
    drain();
    // random phases, gaps only in the first part
    for (int ph = 0; ph < 24; ph++) begin
      random_setting(ph);
      for (int i = 0; i < 50; i++) send(pick_dist(), ph < 18);
      start <= 0;
      drain();
    end
    $display("covered %0d results over %0d register writes, straights and arcs both ways",
             points_seen, n_cfg);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
